>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the latent factor update block.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> sv/sgdlf_pkg.sv
// Package for the latent factor update block: payload types, codes, widths,
// the state enum and fixed-point helpers. Depends on nothing.
`default_nettype none
package sgdlf_pkg;

  localparam int unsigned VECTOR_LENGTH_DEF = 20;
  localparam int unsigned MOVIE_COUNT_DEF   = 1024;
  localparam int unsigned USER_COUNT_DEF    = 1024;

  localparam int unsigned CFG_W   = 25;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned Q_SHIFT = 24;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned EL_W    = 5;

  localparam logic [CFG_W-1:0] STEP_RESET = 25'd16777;
  localparam logic [CFG_W-1:0] REG_RESET  = 25'd16777;

  // Register addresses (index into the register list)
  localparam logic [0:0] REG_STEP = 1'b0;
  localparam logic [0:0] REG_LAMBDA = 1'b1;

  // Function codes
  localparam logic [2:0] FN_LOAD   = 3'd0;
  localparam logic [2:0] FN_UPDATE = 3'd1;
  localparam logic [2:0] FN_EVAL   = 3'd2;
  localparam logic [2:0] FN_READ   = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic               side;
    logic [IDX_W-1:0]   movie_index;
    logic [IDX_W-1:0]   user_index;
    logic [EL_W-1:0]    element;
    logic signed [31:0] load_value;
    logic signed [31:0] rating;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic signed [31:0] prediction_error;
    logic [ACC_W-1:0]   squared_error_sum;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT_RD,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_ERR,
    ST_EVAL_MUL,
    ST_UPD_RD,
    ST_UPD_MUL1,
    ST_UPD_SUB,
    ST_UPD_MUL2,
    ST_UPD_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  // Saturate a signed 40-bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/sgd_latent_factor_update.sv
// Top level of the latent factor SGD update block: control, arithmetic,
// registers. Depends on sgdlf_pkg, sgdlf_store and assert_macros.svh.
//
//  port group | direction | handshake          | payload
//  in_*       | in        | in_valid/in_ready  | sgdlf_pkg::req_t
//  out_*      | out       | out_valid/out_ready| sgdlf_pkg::rsp_t
//  cfg_*      | in        | APB psel/penable   | step, lambda
//
// The dot product steps through read, multiply and add for each element and
// the update through read, multiply, subtract, multiply and write, using the
// single port of each store. One item is in work at a time; in_ready is high
// again once the result sits in the output register, and the next item holds
// in its last cycle until that result leaves. Reset is synchronous, active
// low; stores need no clear.
`default_nettype none
`include "assert_macros.svh"
module sgd_latent_factor_update #(
  parameter int unsigned VECTOR_LENGTH = sgdlf_pkg::VECTOR_LENGTH_DEF,
  parameter int unsigned MOVIE_COUNT   = sgdlf_pkg::MOVIE_COUNT_DEF,
  parameter int unsigned USER_COUNT    = sgdlf_pkg::USER_COUNT_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sgdlf_pkg::req_t     in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output sgdlf_pkg::rsp_t     out_data,
  input  wire                 cfg_psel,
  input  wire                 cfg_penable,
  input  wire                 cfg_pwrite,
  input  wire  [2:0]          cfg_paddr,
  input  wire  [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int unsigned MDEPTH = MOVIE_COUNT * VECTOR_LENGTH;
  localparam int unsigned UDEPTH = USER_COUNT * VECTOR_LENGTH;
  localparam int unsigned MA_W = $clog2(MDEPTH);
  localparam int unsigned UA_W = $clog2(UDEPTH);
  localparam int unsigned EC_W = $clog2(VECTOR_LENGTH + 1);
  localparam int unsigned DOT_W = 40 + EC_W;

  // Configuration registers
  logic [sgdlf_pkg::CFG_W-1:0] step_r, lambda_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= sgdlf_pkg::STEP_RESET;
      lambda_r <= sgdlf_pkg::REG_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == sgdlf_pkg::REG_STEP) begin
        step_r <= cfg_pwdata[sgdlf_pkg::CFG_W-1:0];
      end else begin
        lambda_r <= cfg_pwdata[sgdlf_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'd0) begin
      cfg_prdata = (cfg_paddr[2] == sgdlf_pkg::REG_STEP) ? {7'd0, step_r}
                                                         : {7'd0, lambda_r};
    end
  end

  // Control and datapath registers
  sgdlf_pkg::state_t state_r, state_nxt;
  sgdlf_pkg::req_t   req_r;
  logic [EC_W-1:0]   el_r, el_nxt;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [31:0] err_r, gm_r, gu_r, m_r, u_r;
  logic [sgdlf_pkg::ACC_W-1:0] acc_r;
  logic out_valid_r;
  sgdlf_pkg::rsp_t out_r;
  logic done_seen_r;
  logic load_out;

  // Memory ports
  logic m_we, u_we;
  logic [MA_W-1:0] m_addr;
  logic [UA_W-1:0] u_addr;
  logic [31:0] m_wdata, u_wdata, m_rdata, u_rdata;

  sgdlf_store #(.DEPTH(MDEPTH)) u_movie (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
  sgdlf_store #(.DEPTH(UDEPTH)) u_user (
    .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata));

  // Decode of the held request
  logic mi_ok, ui_ok, el_ok, side_ok;
  logic [MA_W+EC_W:0] m_base, u_base;
  assign mi_ok = 32'(req_r.movie_index) < MOVIE_COUNT;
  assign ui_ok = 32'(req_r.user_index) < USER_COUNT;
  assign el_ok = 32'(req_r.element) < VECTOR_LENGTH;
  assign side_ok = req_r.side ? ui_ok : mi_ok;
  assign m_base = (MA_W+EC_W+1)'(req_r.movie_index * VECTOR_LENGTH);
  assign u_base = (MA_W+EC_W+1)'(req_r.user_index * VECTOR_LENGTH);

  always_comb begin
    logic [MA_W+EC_W:0] ea;
    ea = (MA_W+EC_W+1)'(req_r.element);
    m_addr = (state_r == sgdlf_pkg::ST_IDLE || state_r == sgdlf_pkg::ST_RD_WAIT)
             ? MA_W'(m_base + ea) : MA_W'(m_base + (MA_W+EC_W+1)'(el_r));
    u_addr = (state_r == sgdlf_pkg::ST_IDLE || state_r == sgdlf_pkg::ST_RD_WAIT)
             ? UA_W'(u_base + ea) : UA_W'(u_base + (MA_W+EC_W+1)'(el_r));
  end

  // Element update terms
  logic signed [39:0] gm_diff, gu_diff, m_new, u_new;
  assign gm_diff = 40'(p0_r >>> sgdlf_pkg::Q_SHIFT) - 40'(p1_r >>> sgdlf_pkg::Q_SHIFT);
  assign gu_diff = 40'(p2_r >>> sgdlf_pkg::Q_SHIFT) - 40'(p3_r >>> sgdlf_pkg::Q_SHIFT);
  assign m_new = 40'(m_r) + 40'(p0_r >>> sgdlf_pkg::Q_SHIFT);
  assign u_new = 40'(u_r) + 40'(p2_r >>> sgdlf_pkg::Q_SHIFT);
  assign m_wdata = (state_r == sgdlf_pkg::ST_UPD_WR) ? sgdlf_pkg::sat32(m_new)
                                                     : req_r.load_value;
  assign u_wdata = (state_r == sgdlf_pkg::ST_UPD_WR) ? sgdlf_pkg::sat32(u_new)
                                                     : req_r.load_value;

  logic last_el;
  assign last_el = el_r == EC_W'(VECTOR_LENGTH - 1);

  // Next state and memory writes
  always_comb begin
    state_nxt = state_r;
    el_nxt = el_r;
    m_we = 1'b0;
    u_we = 1'b0;
    case (state_r)
      sgdlf_pkg::ST_IDLE: begin
        if (in_valid && in_ready) state_nxt = sgdlf_pkg::ST_RD_WAIT;
      end
      sgdlf_pkg::ST_RD_WAIT: begin
        el_nxt = '0;
        state_nxt = sgdlf_pkg::ST_DONE;
        if (req_r.func == sgdlf_pkg::FN_LOAD && side_ok && el_ok) begin
          m_we = !req_r.side;
          u_we = req_r.side;
        end
        if ((req_r.func == sgdlf_pkg::FN_UPDATE || req_r.func == sgdlf_pkg::FN_EVAL)
            && mi_ok && ui_ok) state_nxt = sgdlf_pkg::ST_DOT_RD;
      end
      sgdlf_pkg::ST_DOT_RD:  state_nxt = sgdlf_pkg::ST_DOT_MUL;
      sgdlf_pkg::ST_DOT_MUL: state_nxt = sgdlf_pkg::ST_DOT_ACC;
      sgdlf_pkg::ST_DOT_ACC: begin
        el_nxt = el_r + 1'b1;
        state_nxt = sgdlf_pkg::ST_DOT_RD;
        if (last_el) begin
          el_nxt = '0;
          state_nxt = sgdlf_pkg::ST_ERR;
        end
      end
      sgdlf_pkg::ST_ERR: state_nxt = (req_r.func == sgdlf_pkg::FN_EVAL)
                                     ? sgdlf_pkg::ST_EVAL_MUL : sgdlf_pkg::ST_UPD_RD;
      sgdlf_pkg::ST_EVAL_MUL: state_nxt = sgdlf_pkg::ST_DONE;
      sgdlf_pkg::ST_UPD_RD:   state_nxt = sgdlf_pkg::ST_UPD_MUL1;
      sgdlf_pkg::ST_UPD_MUL1: state_nxt = sgdlf_pkg::ST_UPD_SUB;
      sgdlf_pkg::ST_UPD_SUB:  state_nxt = sgdlf_pkg::ST_UPD_MUL2;
      sgdlf_pkg::ST_UPD_MUL2: state_nxt = sgdlf_pkg::ST_UPD_WR;
      sgdlf_pkg::ST_UPD_WR: begin
        m_we = 1'b1;
        u_we = 1'b1;
        el_nxt = el_r + 1'b1;
        state_nxt = sgdlf_pkg::ST_UPD_RD;
        if (last_el) state_nxt = sgdlf_pkg::ST_DONE;
      end
      sgdlf_pkg::ST_DONE: begin
        if (load_out) state_nxt = sgdlf_pkg::ST_IDLE;
      end
      default: state_nxt = sgdlf_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == sgdlf_pkg::ST_IDLE);

  // Hold state and the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgdlf_pkg::ST_IDLE;
      el_r    <= '0;
    end else begin
      state_r <= state_nxt;
      el_r    <= el_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk) begin
    case (state_r)
      sgdlf_pkg::ST_RD_WAIT: dot_r <= '0;
      sgdlf_pkg::ST_DOT_MUL: p0_r <= 64'($signed(m_rdata)) * 64'($signed(u_rdata));
      sgdlf_pkg::ST_DOT_ACC: dot_r <= dot_r + DOT_W'(p0_r >>> sgdlf_pkg::Q_SHIFT);
      sgdlf_pkg::ST_ERR: begin
        err_r <= sgdlf_pkg::sat32(40'(req_r.rating) -
                 40'(sgdlf_pkg::sat32(dot_r > DOT_W'(64'sh7fffffff) ? 40'sh7fffffff :
                 dot_r < -DOT_W'(64'sh80000000) ? -40'sh80000000 : 40'(dot_r))));
      end
      sgdlf_pkg::ST_EVAL_MUL: p0_r <= 64'(err_r) * 64'(err_r);
      sgdlf_pkg::ST_UPD_MUL1: begin
        m_r  <= m_rdata;
        u_r  <= u_rdata;
        p0_r <= 64'(err_r) * 64'($signed(u_rdata));
        p1_r <= 64'($signed({1'b0, lambda_r})) * 64'($signed(m_rdata));
        p2_r <= 64'(err_r) * 64'($signed(m_rdata));
        p3_r <= 64'($signed({1'b0, lambda_r})) * 64'($signed(u_rdata));
      end
      sgdlf_pkg::ST_UPD_SUB: begin
        gm_r <= sgdlf_pkg::sat32(gm_diff);
        gu_r <= sgdlf_pkg::sat32(gu_diff);
      end
      sgdlf_pkg::ST_UPD_MUL2: begin
        p0_r <= 64'($signed({1'b0, step_r})) * 64'(gm_r);
        p2_r <= 64'($signed({1'b0, step_r})) * 64'(gu_r);
      end
      default: ;
    endcase
  end

  // Mark the first cycle in DONE so the sum is added once
  always_ff @(posedge clk) begin
    if (!rst_n) done_seen_r <= 1'b0;
    else done_seen_r <= (state_r == sgdlf_pkg::ST_DONE);
  end

  // Accumulator of squared errors, saturating
  logic [sgdlf_pkg::ACC_W:0] acc_sum;
  assign acc_sum = {1'b0, acc_r} + (sgdlf_pkg::ACC_W+1)'(p0_r[63:sgdlf_pkg::Q_SHIFT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (state_r == sgdlf_pkg::ST_RD_WAIT && req_r.func == sgdlf_pkg::FN_CLEAR) begin
      acc_r <= '0;
    end else if (state_r == sgdlf_pkg::ST_DONE && !done_seen_r &&
                 req_r.func == sgdlf_pkg::FN_EVAL && mi_ok && ui_ok) begin
      acc_r <= acc_sum[sgdlf_pkg::ACC_W] ? '1 : acc_sum[sgdlf_pkg::ACC_W-1:0];
    end
  end

  // Read data captured from the store's registered read in the first cycle of DONE
  logic signed [31:0] rd_r;
  always_ff @(posedge clk) begin
    if (state_r == sgdlf_pkg::ST_DONE && !done_seen_r) begin
      rd_r <= req_r.side ? u_rdata : m_rdata;
    end
  end

  // Output register: load once per item, drop on acceptance
  assign load_out = state_r == sgdlf_pkg::ST_DONE && (!out_valid_r || out_ready) &&
                    done_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.read_value <= (req_r.func == sgdlf_pkg::FN_READ && side_ok && el_ok)
                          ? rd_r : '0;
      out_r.prediction_error <= ((req_r.func == sgdlf_pkg::FN_UPDATE ||
                                  req_r.func == sgdlf_pkg::FN_EVAL) && mi_ok && ui_ok)
                                ? err_r : '0;
      out_r.squared_error_sum <= acc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !load_out,
               "result overwritten while stalled")
  `ASSERT_IMPL(a_wr_in_update, clk, rst_n, m_we && u_we,
               state_r == sgdlf_pkg::ST_UPD_WR, "paired store write outside update")
  `ASSERT_NEXT(a_accept_idle, clk, rst_n, in_valid && in_ready,
               state_r == sgdlf_pkg::ST_RD_WAIT, "accepted request not decoded")

endmodule
`default_nettype wire

>>> sv/sgdlf_store.sv
// Latent vector store: one synchronous single-port memory with a registered read.
// Depends on sgdlf_pkg for the data width.
`default_nettype none
module sgdlf_store #(
  parameter int unsigned DEPTH = 20480
) (
  input  wire                            clk,
  input  wire                            we,
  input  wire  [$clog2(DEPTH)-1:0]       addr,
  input  wire  [sgdlf_pkg::DATA_W-1:0]   wdata,
  output logic [sgdlf_pkg::DATA_W-1:0]   rdata
);

  logic [sgdlf_pkg::DATA_W-1:0] mem [DEPTH];

  // Write one entry and read one entry per cycle; a write reads the old content
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> verif/tb_sgd_latent_factor_update.sv
// Testbench for sgd_latent_factor_update: drives load, update, evaluate, read,
// clear and unused-code requests and checks every result against an in-bench predictor.
// Depends on sgdlf_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_sgd_latent_factor_update;

  localparam int VLEN = 20;
  localparam int NIDX = 1024;
  localparam int LIMIT = 20000;
  localparam int NROWS = 11;
  localparam logic [2:0] FN_RSV5 = 3'd5;
  localparam logic [2:0] FN_RSV6 = 3'd6;
  localparam logic [2:0] FN_BAD = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sgdlf_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sgdlf_pkg::rsp_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sgd_latent_factor_update DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: shadow stores, sum and registers
  logic signed [31:0] movie_mem [NIDX*VLEN];
  logic signed [31:0] user_mem [NIDX*VLEN];
  logic [47:0] err_sum;
  longint step_q, lambda_q;

  sgdlf_pkg::rsp_t expected_rsp[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;

  function automatic longint floor24(longint v);
    return v >>> 24;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Compute the result of one request and advance the shadow state
  function automatic sgdlf_pkg::rsp_t predict_rsp(sgdlf_pkg::req_t r);
    sgdlf_pkg::rsp_t o;
    int base, a, mb, ub;
    longint dot, err, pm, pu, gu, gm, s;
    o = '0;
    base = r.side ? int'(r.user_index) : int'(r.movie_index);
    a = base * VLEN + int'(r.element);
    if (r.func == sgdlf_pkg::FN_LOAD || r.func == sgdlf_pkg::FN_READ) begin
      if (r.element < VLEN) begin
        if (r.func == sgdlf_pkg::FN_READ) o.read_value = r.side ? user_mem[a] : movie_mem[a];
        else if (r.side) user_mem[a] = r.load_value;
        else movie_mem[a] = r.load_value;
      end
    end else if (r.func == sgdlf_pkg::FN_UPDATE || r.func == sgdlf_pkg::FN_EVAL) begin
      mb = int'(r.movie_index) * VLEN;
      ub = int'(r.user_index) * VLEN;
      dot = 0;
      for (int i = 0; i < VLEN; i++)
        dot += floor24(longint'(movie_mem[mb+i]) * longint'(user_mem[ub+i]));
      err = clip32(longint'(r.rating) - clip32(dot));
      o.prediction_error = err[31:0];
      if (r.func == sgdlf_pkg::FN_UPDATE) begin
        for (int i = 0; i < VLEN; i++) begin
          pm = movie_mem[mb+i];
          pu = user_mem[ub+i];
          gu = clip32(floor24(err * pm) - floor24(lambda_q * pu));
          gm = clip32(floor24(err * pu) - floor24(lambda_q * pm));
          user_mem[ub+i] = 32'(clip32(pu + floor24(step_q * gu)));
          movie_mem[mb+i] = 32'(clip32(pm + floor24(step_q * gm)));
        end
      end else begin
        s = longint'(err_sum) + floor24(err * err);
        err_sum = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
      end
    end else if (r.func == sgdlf_pkg::FN_CLEAR) begin
      err_sum = '0;
    end
    o.squared_error_sum = err_sum;
    return o;
  endfunction

  // Send one request; hold valid until accepted, drop it only to idle
  task automatic send_req(sgdlf_pkg::req_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsp = {expected_rsp, predict_rsp(r)};
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00};
    cfg_penable <= 1'b0; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == sgdlf_pkg::REG_STEP) step_q = v[24:0];
    else lambda_q = v[24:0];
    @(posedge clk);
  endtask

  // Receiver: random stall, compare each result with the oldest expectation
  always @(posedge clk) begin
    sgdlf_pkg::rsp_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          e = expected_rsp.pop_front();
          if (out_data !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp rd=%h err=%h sum=%h got rd=%h err=%h sum=%h",
                e.read_value, e.prediction_error, e.squared_error_sum,
                out_data.read_value, out_data.prediction_error,
                out_data.squared_error_sum);
          end
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      // Watchdog on cycles with no accepted request or result
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic sgdlf_pkg::req_t mk(logic [2:0] f, logic sd, int m, int u, int el,
                                         logic [31:0] lv, logic [31:0] rt);
    sgdlf_pkg::req_t r;
    r.func = f; r.side = sd; r.movie_index = 10'(m); r.user_index = 10'(u);
    r.element = 5'(el); r.load_value = lv; r.rating = rt;
    return r;
  endfunction

  // Load a full vector pair with random small or extreme content
  task automatic load_pair(int m, int u, bit wild);
    for (int i = 0; i < VLEN; i++) begin
      send_req(mk(sgdlf_pkg::FN_LOAD, 0, m, $urandom, i,
        wild ? $urandom : $signed($urandom_range(65535, 0)) * 512 - 32'sd16777216, 0));
      send_req(mk(sgdlf_pkg::FN_LOAD, 1, $urandom, u, i,
        wild ? $urandom : $signed($urandom_range(65535, 0)) * 512 - 32'sd16777216, 0));
    end
  endtask

  // Pick a random request that only touches written elements
  function automatic sgdlf_pkg::req_t rand_req(int m, int u);
    sgdlf_pkg::req_t r;
    int k;
    r = '0;
    r.movie_index = 10'(m); r.user_index = 10'(u);
    r.rating = $urandom_range(3, 0) == 0 ? $urandom
             : $signed($urandom_range(100, 0)) * 32'sd838861;
    r.load_value = $urandom;
    r.side = 1'($urandom);
    r.element = 5'($urandom_range(VLEN-1, 0));
    k = $urandom_range(99, 0);
    if (k < 30) r.func = sgdlf_pkg::FN_UPDATE;
    else if (k < 50) r.func = sgdlf_pkg::FN_EVAL;
    else if (k < 70) r.func = sgdlf_pkg::FN_READ;
    else if (k < 85) r.func = sgdlf_pkg::FN_LOAD;
    else if (k < 90) r.func = sgdlf_pkg::FN_CLEAR;
    else begin
      // Junk codes, and reads past the vector end
      r.func = $urandom_range(1, 0) ? 3'(FN_BAD - $urandom_range(2, 0))
                                    : sgdlf_pkg::FN_READ;
      r.element = 5'($urandom_range(31, VLEN));
    end
    return r;
  endfunction

  typedef struct {
    sgdlf_pkg::req_t r;
    bit check;
    sgdlf_pkg::rsp_t e;
  } row_t;

  row_t dir_rows[NROWS];
  int pm_, pu_;
  sgdlf_pkg::rsp_t got;

  initial begin
    err_sum = '0;
    step_q = sgdlf_pkg::STEP_RESET;
    lambda_q = sgdlf_pkg::REG_RESET;
    foreach (movie_mem[i]) begin movie_mem[i] = 0; user_mem[i] = 0; end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; rows with check set carry a hand-written result
    dir_rows[0] = '{mk(sgdlf_pkg::FN_READ, 0, 0, 0, 20, 0, 0), 1, '0};
    dir_rows[1] = '{mk(sgdlf_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0), 1, '0};
    dir_rows[2] = '{mk(FN_BAD, 1, 1023, 1023, 31, '1, '1), 1, '0};
    dir_rows[3] = '{mk(sgdlf_pkg::FN_LOAD, 0, 1023, 0, 19, 32'h7fffffff, 0), 1, '0};
    dir_rows[4] = '{mk(sgdlf_pkg::FN_LOAD, 1, 0, 1023, 19, 32'h80000000, 0), 1, '0};
    dir_rows[5] = '{mk(sgdlf_pkg::FN_READ, 0, 1023, 0, 19, 0, 0), 1,
                    '{32'sh7fffffff, 0, 0}};
    dir_rows[6] = '{mk(sgdlf_pkg::FN_READ, 1, 0, 1023, 19, 0, 0), 1,
                    '{32'sh80000000, 0, 0}};
    dir_rows[7] = '{mk(sgdlf_pkg::FN_READ, 1, 0, 1023, 20, 0, 0), 1, '0};
    dir_rows[8] = '{mk(sgdlf_pkg::FN_LOAD, 1, 0, 1023, 31, 5, 0), 1, '0};
    dir_rows[9] = '{mk(FN_RSV5, 0, 0, 0, 0, 0, 0), 1, '0};
    dir_rows[10] = '{mk(FN_RSV6, 0, 0, 0, 0, 0, 0), 1, '0};
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].r);
      if (dir_rows[i].check) begin
        got = expected_rsp[$];
        if (got !== dir_rows[i].e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: exp %h pred %h", i, dir_rows[i].e, got);
        end
      end
    end
    wait_drain();

    // Extreme vectors, update and evaluate saturate both ways
    load_pair(1023, 1023, 1);
    send_req(mk(sgdlf_pkg::FN_EVAL, 0, 1023, 1023, 0, 0, 32'h7fffffff));
    send_req(mk(sgdlf_pkg::FN_EVAL, 0, 1023, 1023, 0, 0, 32'h80000000));
    send_req(mk(sgdlf_pkg::FN_UPDATE, 0, 1023, 1023, 0, 0, 32'h80000000));
    send_req(mk(sgdlf_pkg::FN_UPDATE, 0, 1023, 1023, 0, 0, 32'h7fffffff));
    wait_drain();

    // Random phases: each with a register setting and an idle profile
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(sgdlf_pkg::REG_STEP, 32'h01000000);
          write_reg(sgdlf_pkg::REG_LAMBDA, 0);
        end
        1: begin
          write_reg(sgdlf_pkg::REG_STEP, 0);
          write_reg(sgdlf_pkg::REG_LAMBDA, 32'h01000000);
        end
        2: begin
          write_reg(sgdlf_pkg::REG_STEP, 32'hffffffff);
          write_reg(sgdlf_pkg::REG_LAMBDA, 32'hfe000001);
        end
        default: begin
          write_reg(sgdlf_pkg::REG_STEP, $urandom_range(1 << 20, 0));
          write_reg(sgdlf_pkg::REG_LAMBDA, $urandom_range(1 << 20, 0));
        end
      endcase
      send_idle_pct = ph < 2 ? 9 : (ph < 4 ? 72 : 0);
      recv_idle_pct = ph < 2 ? 72 : (ph < 4 ? 9 : 0);
      for (int s = 0; s < 4; s++) begin
        pm_ = $urandom_range(NIDX-1, 0);
        pu_ = $urandom_range(NIDX-1, 0);
        load_pair(pm_, pu_, $urandom_range(4, 0) == 0);
        repeat (40) send_req(rand_req(pm_, pu_));
      end
      wait_drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;

    if (mismatches == 0 && expected_rsp.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/sgdlf_pkg.sv
sv/sgdlf_store.sv
sv/sgd_latent_factor_update.sv
verif/tb_sgd_latent_factor_update.sv
